// ----- design/ldru_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldru_pkg
// Shared constants and types for the pipelined signed/unsigned divider.
// ----------------------------------------------------------------------------
package ldru_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CMD_WIDTH  = 2;

    // command bit positions
    localparam int CMD_UNSIGNED_BIT = 0;
    localparam int CMD_REMAINDER_BIT = 1;

    // control that travels alongside each operation
    typedef struct packed {
        logic want_rem;   // return remainder instead of quotient
        logic neg_quo;    // negate the final quotient
        logic neg_rem;    // negate the final remainder
        logic zero_div;   // divisor was zero: force result to zero
    } ldru_ctrl_t;

endpackage

// ----- design/long_divide_remainder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// long_divide_remainder_unit
// Pipelined restoring divider returning quotient or remainder, signed or
// unsigned, with truncation toward zero.
// ----------------------------------------------------------------------------
// The unit accepts one division per clock while the output is not stalled
// and passes it through its stages: one stage takes operand magnitudes, one
// restoring step per stage produces one quotient bit (DATA_WIDTH stages), and
// a last stage applies the signs into the output register. A stall on the
// result side freezes the whole pipeline, so a full pipeline sustains one
// transfer per cycle. Signed results truncate toward
// zero, the remainder follows the sign of the dividend, a zero divisor yields
// zero, and the most negative value divided by -1 wraps to itself with a zero
// remainder.
module long_divide_remainder_unit #(
    parameter int DATA_WIDTH = ldru_pkg::DATA_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [ldru_pkg::CMD_WIDTH-1:0] command,
    input  logic [DATA_WIDTH-1:0]          dividend,
    input  logic [DATA_WIDTH-1:0]          divisor,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [DATA_WIDTH-1:0]          result
);

    localparam int W = DATA_WIDTH;

    logic advance;

    // stage registers; index 0 holds magnitudes, index k holds k quotient bits
    logic                 valid_reg [0:W];
    logic [W-1:0]         rem_reg   [0:W];
    logic [W-1:0]         quo_reg   [0:W];
    logic [W-1:0]         div_reg   [0:W];
    ldru_pkg::ldru_ctrl_t ctrl_reg  [0:W];

    logic                 rsp_valid_reg;
    logic [W-1:0]         result_reg;
    logic [W-1:0]         result_next;

    logic                 is_signed;
    logic                 neg_a;
    logic                 neg_b;
    ldru_pkg::ldru_ctrl_t ctrl_next;
    logic [W-1:0]         abs_a_next;
    logic [W-1:0]         abs_b_next;

    // move everything forward unless a finished result is held
    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !advance;
    assign rsp_valid = rsp_valid_reg;
    assign result    = result_reg;

    // ------------------------------------------------------------------------
    // Entry stage: operand magnitudes and sign control
    // ------------------------------------------------------------------------
    always_comb
    begin
        is_signed          = !command[ldru_pkg::CMD_UNSIGNED_BIT];
        neg_a              = is_signed && dividend[W-1];
        neg_b              = is_signed && divisor[W-1];
        abs_a_next         = neg_a ? (~dividend + W'(1)) : dividend;
        abs_b_next         = neg_b ? (~divisor + W'(1)) : divisor;
        ctrl_next.want_rem = command[ldru_pkg::CMD_REMAINDER_BIT];
        ctrl_next.neg_quo  = neg_a ^ neg_b;
        ctrl_next.neg_rem  = neg_a;
        ctrl_next.zero_div = (divisor == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0]  <= '0;
            quo_reg[0]  <= abs_a_next;
            div_reg[0]  <= abs_b_next;
            ctrl_reg[0] <= ctrl_next;
        end
    end

    // ------------------------------------------------------------------------
    // Restoring steps: one quotient bit per stage
    // ------------------------------------------------------------------------
    for (genvar k = 1; k <= W; k++)
    begin : g_step
        logic [W:0]   shifted;
        logic [W:0]   diff;
        logic [W-1:0] rem_next;
        logic [W-1:0] quo_next;

        always_comb
        begin
            shifted = {rem_reg[k-1], quo_reg[k-1][W-1]};
            diff    = shifted - {1'b0, div_reg[k-1]};
            // keep the trial difference when it did not go negative
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[k-1][W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[k-1][W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                div_reg[k]  <= div_reg[k-1];
                ctrl_reg[k] <= ctrl_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output stage: select, apply sign, zero-divisor override
    // ------------------------------------------------------------------------
    always_comb
    begin
        if (ctrl_reg[W].zero_div)
        begin
            result_next = '0;
        end
        else if (ctrl_reg[W].want_rem)
        begin
            result_next = ctrl_reg[W].neg_rem ? (~rem_reg[W] + W'(1)) : rem_reg[W];
        end
        else
        begin
            result_next = ctrl_reg[W].neg_quo ? (~quo_reg[W] + W'(1)) : quo_reg[W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= valid_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_zero_div_result: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[W] && ctrl_reg[W].zero_div && advance |=> result_reg == '0)
        else $error("zero divisor did not produce a zero result");

    a_divisor_magnitude: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] && !ctrl_reg[0].zero_div |-> div_reg[0] != '0)
        else $error("divisor magnitude lost alongside a nonzero divisor");

    a_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[W] && !ctrl_reg[W].zero_div |-> rem_reg[W] < div_reg[W])
        else $error("final remainder not below divisor");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(valid_reg[W]) && $stable(rem_reg[W]) && $stable(quo_reg[W]))
        else $error("pipeline moved while the output was stalled");

endmodule

// ----- sim/ldru_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldru_checker
// Watches both channels of the divider, predicts each result from the accepted
// request and compares it in order against what the unit returns.
// ----------------------------------------------------------------------------
module ldru_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  logic                            req_stall,
    input  logic [ldru_pkg::CMD_WIDTH-1:0]  command,
    input  logic [ldru_pkg::DATA_WIDTH-1:0] dividend,
    input  logic [ldru_pkg::DATA_WIDTH-1:0] divisor,
    input  logic                            rsp_valid,
    input  logic                            rsp_stall,
    input  logic [ldru_pkg::DATA_WIDTH-1:0] result,
    output int                              mismatch_count,
    output int                              outstanding,
    output int                              results_seen
);

    localparam int REPORT_LIMIT = 10;
    localparam int DW           = ldru_pkg::DATA_WIDTH;
    localparam int CW           = ldru_pkg::CMD_WIDTH;

    typedef struct {
        logic [CW-1:0] cmd;
        logic [DW-1:0] num;
        logic [DW-1:0] den;
        logic [DW-1:0] value;
    } division_t;

    division_t pending_divisions [$];

    initial
    begin
        mismatch_count = 0;
        results_seen   = 0;
    end

    assign outstanding = pending_divisions.size();

    // Truncating division on magnitudes, signs applied afterward.
    function automatic logic [DW-1:0] predict_div_result(
        logic [CW-1:0] cmd,
        logic [DW-1:0] num,
        logic [DW-1:0] den
    );
        logic          is_uns;
        logic          neg_num;
        logic          neg_den;
        logic [DW-1:0] mag_num;
        logic [DW-1:0] mag_den;
        logic [DW-1:0] quo;
        logic [DW-1:0] rem;
        is_uns = cmd[ldru_pkg::CMD_UNSIGNED_BIT];
        if (den == '0)
            return '0;
        neg_num = !is_uns && num[DW-1];
        neg_den = !is_uns && den[DW-1];
        mag_num = neg_num ? -num : num;
        mag_den = neg_den ? -den : den;
        quo = mag_num / mag_den;
        rem = mag_num % mag_den;
        if (cmd[ldru_pkg::CMD_REMAINDER_BIT])
            return neg_num ? -rem : rem;
        return (neg_num ^ neg_den) ? -quo : quo;
    endfunction

    always @(posedge clk)
    begin
        division_t item;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                item.cmd   = command;
                item.num   = dividend;
                item.den   = divisor;
                item.value = predict_div_result(command, dividend, divisor);
                pending_divisions.push_back(item);
            end
            if (rsp_valid && !rsp_stall)
            begin
                results_seen++;
                if (pending_divisions.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result transfer %h", $realtime, result);
                end
                else
                begin
                    item = pending_divisions.pop_front();
                    if (result !== item.value)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: cmd %0d %h / %h: expected %h, got %h",
                                     $realtime, item.cmd, item.num, item.den,
                                     item.value, result);
                    end
                end
            end
        end
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives division requests into long_divide_remainder_unit with random idle
// gaps and output stalls; a checker beside the unit predicts every result.
// ----------------------------------------------------------------------------
module tb;

    localparam int W            = ldru_pkg::DATA_WIDTH;
    localparam int CW           = ldru_pkg::CMD_WIDTH;
    localparam int RANDOM_ITEMS = 1800;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = W + 4;

    localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] ALL_ONES = '1;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    logic [CW-1:0]  command   = '0;
    logic [W-1:0]   dividend  = '0;
    logic [W-1:0]   divisor   = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    logic [W-1:0]   result;

    logic           steady     = 1'b0;
    int             stall_left = 0;
    int             idle_cycles = 0;
    int             mismatch_count;
    int             outstanding;
    int             results_seen;
    int             sent_count  = 0;
    int             zero_den_count = 0;
    int             overflow_count = 0;

    always #5 clk = ~clk;

    long_divide_remainder_unit #(.DATA_WIDTH(W)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .command   (command),
        .dividend  (dividend),
        .divisor   (divisor),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .result    (result)
    );

    ldru_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .command        (command),
        .dividend       (dividend),
        .divisor        (divisor),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .result         (result),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .results_seen   (results_seen)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [W-1:0] pick_operand();
        int           roll;
        logic [W-1:0] val;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            val = $urandom();
        else if (roll < 55)
            val = $urandom_range(1, 15);
        else if (roll < 63)
            val = '0;
        else if (roll < 71)
            val = ALL_ONES;
        else if (roll < 79)
            val = MOST_NEG;
        else if (roll < 86)
            val = MOST_POS;
        else
            val = {{(W-1){1'b0}}, 1'b1} << $urandom_range(0, W-1);
        // flip sign on some small and power-of-two picks
        if (roll >= 40 && roll < 55 && $urandom_range(0, 1))
            val = -val;
        if (roll >= 86 && $urandom_range(0, 1))
            val = -val;
        return val;
    endfunction

    task automatic send_division(logic [CW-1:0] cmd, logic [W-1:0] num,
                                 logic [W-1:0] den);
        int gap;
        gap = steady ? 0 : pick_idle_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        command   <= cmd;
        dividend  <= num;
        divisor   <= den;
        // hold the payload until the transfer happens
        do
            @(posedge clk);
        while (req_stall);
        sent_count++;
        if (den == '0)
            zero_den_count++;
        if (!cmd[ldru_pkg::CMD_UNSIGNED_BIT] && num == MOST_NEG && den == ALL_ONES)
            overflow_count++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (!steady && $urandom_range(0, 99) < 30)
        begin
            rsp_stall  <= 1'b1;
            stall_left <= pick_idle_len();
        end
        else
        begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("long_divide_remainder_unit verification failed");
        $finish;
    end

    initial
    begin
        logic [W-1:0] dir_num [6];
        logic [W-1:0] dir_den [6];
        dir_num = '{MOST_NEG, 32'h1234_5678, ALL_ONES, -32'sd7, 32'd7, '0};
        dir_den = '{ALL_ONES, '0, 32'd1, 32'd2, -32'sd2, ALL_ONES};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // overflow, zero divisor, extremes and sign combinations for every command
        for (int c = 0; c < 2**CW; c++)
            for (int k = 0; k < 6; k++)
                send_division(c[CW-1:0], dir_num[k], dir_den[k]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
                steady <= ($urandom_range(0, 3) == 0);
            send_division(CW'($urandom_range(0, 2**CW - 1)), pick_operand(),
                          pick_operand());
        end
        req_valid <= 1'b0;
        steady    <= 1'b1;

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d divisions across all four commands, %0d results returned.",
                 sent_count, results_seen);
        $display("Zero divisors: %0d, signed overflow cases: %0d, mismatches: %0d.",
                 zero_den_count, overflow_count, mismatch_count);
        if (mismatch_count == 0 && outstanding == 0)
            $display("long_divide_remainder_unit verification clean");
        else
            $display("long_divide_remainder_unit verification failed");
        $finish;
    end

endmodule

// ----- long_divide_remainder_unit.f -----
design/ldru_pkg.sv
design/long_divide_remainder_unit.sv
sim/ldru_checker.sv
sim/tb.sv
